// ===== hdl/hbc_pkg.sv =====
package hbc_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W = 24;
    localparam int KEY_W = 3;
    localparam int ACT_W = 7;
    localparam int CFG_IDX_W = 4;

    // Key sample classes. Codes above KC_OTHER behave as KC_OTHER.
    localparam logic [KEY_W-1:0] KC_NONE  = 3'd0;
    localparam logic [KEY_W-1:0] KC_B1    = 3'd1;
    localparam logic [KEY_W-1:0] KC_B2    = 3'd2;
    localparam logic [KEY_W-1:0] KC_AMB   = 3'd3;
    localparam logic [KEY_W-1:0] KC_OTHER = 3'd4;

    // Bit positions in the action mask.
    localparam int ACT_EXPIRED = 0;
    localparam int ACT_TAP     = 1;
    localparam int ACT_OPEN    = 2;
    localparam int ACT_WARN    = 3;
    localparam int ACT_ENDWARN = 4;
    localparam int ACT_SLEEP   = 5;
    localparam int ACT_MAINT   = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAIRING_HOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_HOLD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAINT_HOLD   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIRING_WIN  = 4'd3;

    localparam logic [CFG_W-1:0] PAIRING_HOLD_RST = 24'd2000;
    localparam logic [CFG_W-1:0] WARNING_HOLD_RST = 24'd5000;
    localparam logic [CFG_W-1:0] MAINT_HOLD_RST   = 24'd10000;
    localparam logic [CFG_W-1:0] PAIRING_WIN_RST  = 24'd60000;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [KEY_W-1:0]  key_class;
    } in_item_t;

    typedef struct packed {
        logic [ACT_W-1:0] actions;
        logic             pair_live;
        logic [CFG_W-1:0] pair_left_ms;
        logic             warn_live;
        logic [CFG_W-1:0] warn_left_ms;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] pairing_hold_ms;
        logic [CFG_W-1:0] warning_hold_ms;
        logic [CFG_W-1:0] maintenance_hold_ms;
        logic [CFG_W-1:0] pairing_window_ms;
    } cfg_t;

    typedef struct packed {
        logic              first_down;
        logic              second_down;
        logic              rearm_needed;
        logic              pair_fired;
        logic              warn_fired;
        logic              maint_fired;
        logic              window_open;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] window_start;
    } hbc_state_t;

endpackage

// ===== hdl/two_button_hold_classifier.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data   (in_item_t: now_ms, key_class)
// out       output     out_valid / out_ready out_data  (out_item_t: actions, status)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data (24-bit threshold)
//
// Each transaction passes from input to result through the input register and then
// through the step logic into the result register.
// A new input transaction is accepted every cycle while results are taken.
// Throughput is set by the single state update per cycle in the step logic.
// Reset clears the classifier state and loads the default thresholds.
// A stalled output holds its result and the input register keeps one more
// transaction, so the input side only stops when both registers are full.
module two_button_hold_classifier
    import hbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t       cfg;
    in_item_t   in_reg;
    logic       in_valid_reg;
    out_item_t  out_reg;
    logic       out_valid_reg;
    hbc_state_t state_reg;
    hbc_state_t state_next;
    out_item_t  result;
    logic       advance;

    // Configuration writes are always taken; the user must write only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    hbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held sample moves to the result register when that register is
    // empty or is being emptied in this cycle. The state advances with it.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    hbc_step u_step (
        .state      (state_reg),
        .item       (in_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A press on button1 and a hold on button2 are never tracked together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.first_down && state_reg.second_down))
        else $error("both buttons tracked as held");

    // A sleep toggle always leaves button2 tracked as held.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.actions[ACT_SLEEP] |=> state_reg.second_down)
        else $error("sleep toggle without button2 hold");

    // Entering maintenance closes the pairing window in the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.actions[ACT_MAINT] |-> !out_reg.pair_live)
        else $error("pairing still active after maintenance");

    // Status remaining times are zero exactly when their flag is clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.pair_left_ms != '0) == out_reg.pair_live)
            && ((out_reg.warn_left_ms != '0) == out_reg.warn_live))
        else $error("remaining time disagrees with active flag");

    // The state only changes when a transaction moves into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a transaction");

endmodule

// ===== hdl/hbc_cfg.sv =====
module hbc_cfg
    import hbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pairing_hold_ms     <= PAIRING_HOLD_RST;
            cfg_reg.warning_hold_ms     <= WARNING_HOLD_RST;
            cfg_reg.maintenance_hold_ms <= MAINT_HOLD_RST;
            cfg_reg.pairing_window_ms   <= PAIRING_WIN_RST;
        end
        else if (cfg_valid)
        begin
            // Indexes past the last register are dropped.
            case (cfg_index)
                REG_PAIRING_HOLD: cfg_reg.pairing_hold_ms     <= cfg_data;
                REG_WARNING_HOLD: cfg_reg.warning_hold_ms     <= cfg_data;
                REG_MAINT_HOLD:   cfg_reg.maintenance_hold_ms <= cfg_data;
                REG_PAIRING_WIN:  cfg_reg.pairing_window_ms   <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/hbc_step.sv =====
module hbc_step
    import hbc_pkg::*;
(
    input  hbc_state_t state,
    input  in_item_t   item,
    input  cfg_t       cfg,
    output hbc_state_t state_next,
    output out_item_t  result
);

    localparam int PAD_W = TIME_W - CFG_W;

    logic [TIME_W-1:0] win_age;
    logic [TIME_W-1:0] hold_age;
    logic [TIME_W-1:0] new_win_age;
    logic [TIME_W-1:0] ph_ext;
    logic [TIME_W-1:0] wh_ext;
    logic [TIME_W-1:0] mh_ext;
    logic [TIME_W-1:0] pw_ext;
    logic              expire;
    logic              ge_p;
    logic              ge_w;
    logic              ge_m;
    logic              do_open;
    logic              do_warn;
    logic              do_maint;
    logic              opened;
    logic [ACT_W-1:0]  act;
    hbc_state_t        ns;
    logic              p_act;
    logic              w_act;
    logic [KEY_W-1:0]  k;

    assign ph_ext = {{PAD_W{1'b0}}, cfg.pairing_hold_ms};
    assign wh_ext = {{PAD_W{1'b0}}, cfg.warning_hold_ms};
    assign mh_ext = {{PAD_W{1'b0}}, cfg.maintenance_hold_ms};
    assign pw_ext = {{PAD_W{1'b0}}, cfg.pairing_window_ms};

    assign k        = item.key_class;
    assign win_age  = item.now_ms - state.window_start;
    assign hold_age = item.now_ms - state.press_start;
    assign expire   = state.window_open && (win_age >= pw_ext);
    assign ge_p     = hold_age >= ph_ext;
    assign ge_w     = hold_age >= wh_ext;
    assign ge_m     = hold_age >= mh_ext;
    assign do_open  = !state.pair_fired && ge_p;
    assign do_warn  = !state.warn_fired && ge_w;
    assign do_maint = !state.maint_fired && ge_m;

    always_comb
    begin
        ns = state;
        act = '0;
        opened = 1'b0;
        act[ACT_EXPIRED] = expire;
        if (expire)
        begin
            ns.window_open = 1'b0;
        end

        if (state.rearm_needed)
        begin
            if (k == KC_NONE)
            begin
                ns.rearm_needed = 1'b0;
            end
        end
        else if (state.first_down)
        begin
            // Hold progress applies to every sample except KC_OTHER and the codes above it.
            if (k == KC_B1 || k == KC_NONE || k == KC_B2 || k == KC_AMB)
            begin
                if (do_open)
                begin
                    ns.pair_fired   = 1'b1;
                    ns.window_open  = 1'b1;
                    ns.window_start = state.press_start + ph_ext;
                    opened          = 1'b1;
                    act[ACT_OPEN]   = 1'b1;
                end
                if (do_warn)
                begin
                    ns.warn_fired = 1'b1;
                    act[ACT_WARN] = 1'b1;
                end
                if (do_maint)
                begin
                    ns.maint_fired  = 1'b1;
                    ns.window_open  = 1'b0;
                    act[ACT_MAINT]  = 1'b1;
                end
            end
            if (k == KC_NONE)
            begin
                if (!ge_p)
                begin
                    act[ACT_TAP] = 1'b1;
                end
                else if (ge_w && !ge_m)
                begin
                    act[ACT_ENDWARN] = 1'b1;
                end
                ns.first_down = 1'b0;
            end
            else if (k != KC_B1)
            begin
                // Conflicting sample aborts the press.
                if (ns.warn_fired && !ns.maint_fired)
                begin
                    act[ACT_ENDWARN] = 1'b1;
                end
                ns.first_down   = 1'b0;
                ns.rearm_needed = 1'b1;
            end
        end
        else if (state.second_down)
        begin
            if (k != KC_B2)
            begin
                ns.second_down = 1'b0;
                if (k != KC_NONE)
                begin
                    ns.rearm_needed = 1'b1;
                end
            end
        end
        else
        begin
            case (k)
                KC_NONE:
                begin
                    ns.first_down = state.first_down;
                end
                KC_B1:
                begin
                    ns.first_down  = 1'b1;
                    ns.pair_fired  = 1'b0;
                    ns.warn_fired  = 1'b0;
                    ns.maint_fired = 1'b0;
                    ns.press_start = item.now_ms;
                end
                KC_B2:
                begin
                    ns.second_down = 1'b1;
                    act[ACT_SLEEP] = 1'b1;
                end
                default:
                begin
                    ns.rearm_needed = 1'b1;
                end
            endcase
        end
    end

    // The window start only changes when the window opens this step, and then
    // the new age is the hold age less the pairing threshold.
    assign new_win_age = opened ? (hold_age - ph_ext) : win_age;
    assign p_act = ns.window_open && (new_win_age < pw_ext);
    // press_start moves only when a press begins, and then warn_fired is clear.
    assign w_act = ns.first_down && ns.warn_fired && !ns.maint_fired && ge_w && !ge_m;

    assign state_next = ns;

    always_comb
    begin
        result.actions      = act;
        result.pair_live    = p_act;
        result.pair_left_ms = p_act ?
            (cfg.pairing_window_ms - new_win_age[CFG_W-1:0]) : '0;
        result.warn_live    = w_act;
        result.warn_left_ms = w_act ?
            (cfg.maintenance_hold_ms - hold_age[CFG_W-1:0]) : '0;
    end

endmodule
